// ===== src/html_token_splitter_macros.svh =====
// Assertion macros for the HTML token splitter.
// Included by the RTL files that check their own state; needs nothing else.
`ifndef HTML_TOKEN_SPLITTER_MACROS_SVH
`define HTML_TOKEN_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off during reset.
`define HTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("html_token_splitter: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define HTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("html_token_splitter: next-cycle check failed");

`else

`define HTS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/hts_pkg.sv =====
// Shared types, character constants and byte cleaning for the HTML token splitter.
// No dependencies; used by the channel interfaces and the top level.
package hts_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] tkind_t;

    // Token classes on the result channel
    localparam tkind_t KIND_TEXT    = 2'd0;
    localparam tkind_t KIND_TAG     = 2'd1;
    localparam tkind_t KIND_COMMENT = 2'd2;

    // Input word kinds
    localparam logic IN_DATA = 1'b0;
    localparam logic IN_EOF  = 1'b1;

    localparam byte_t CH_LT    = 8'h3C;  // <
    localparam byte_t CH_GT    = 8'h3E;  // >
    localparam byte_t CH_BANG  = 8'h21;  // !
    localparam byte_t CH_DASH  = 8'h2D;  // -
    localparam byte_t CH_DQ    = 8'h22;  // "
    localparam byte_t CH_SQ    = 8'h27;  // '
    localparam byte_t CH_BSL   = 8'h5C;  // backslash
    localparam byte_t CH_QMARK = 8'h3F;  // ?
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_VT    = 8'h0B;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_LOW   = 8'd32;
    localparam byte_t CH_HIGH  = 8'd126;

    // Replace non-printing bytes by '?', keeping the usual whitespace controls
    function automatic byte_t hts_clean(input byte_t b);
        logic printable;
        logic space_ctl;
        printable = (b >= CH_LOW) && (b <= CH_HIGH);
        space_ctl = (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) || (b == CH_CR);
        return (printable || space_ctl) ? b : CH_QMARK;
    endfunction

endpackage

// ===== src/hts_if.sv =====
// Valid/ready channel interfaces of the HTML token splitter: bytes in, tokens out.
// Depends on hts_pkg for the payload types.
interface hts_byte_if
    import hts_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  kind;
    byte_t in_byte;

    modport source (output valid, output kind, output in_byte, input ready);
    modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface hts_token_if
    import hts_pkg::*;
();
    logic   valid;
    logic   ready;
    byte_t  out_char;
    logic   has_char;
    tkind_t token_kind;
    logic   first;
    logic   last;

    modport source (output valid, output out_char, output has_char, output token_kind,
                    output first, output last, input ready);
    modport sink   (input valid, input out_char, input has_char, input token_kind,
                    input first, input last, output ready);
endinterface

// ===== src/html_token_splitter.sv =====
// Top level of the HTML token splitter: input register, lexer state and result register.
// Depends on hts_pkg, hts_if.sv and html_token_splitter_macros.svh.
//
// Usage:
//   rx carries one word per input item: kind 0 with a raw byte in in_byte, or
//   kind 1 to mark end of input. tx returns one word per result: the cleaned
//   byte, whether a byte is present, the token class (text, tag, comment) and
//   first/last flags marking token boundaries. A text token gets last only at
//   end of input; otherwise it ends where the next '<' arrives with first set.
//   End of input with a token open gives a single word with has_char low and
//   last high; end of input with nothing open gives no word at all.
// Timing:
//   A word taken on rx sits in the input register, is decided by the lexer
//   logic and is loaded into the result register, which drives tx.
//   One word is taken per cycle as long as tx takes results; the rate is set
//   by the lexer step from the input register to the result register.
// Reset and stall:
//   rst_n clears both valid flags and returns the lexer to idle, no token open.
//   When tx stalls, the result holds, the word behind it waits in the input
//   register, and rx ready drops until the result is taken.
`include "html_token_splitter_macros.svh"

module html_token_splitter
    import hts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hts_byte_if.sink    rx,
    hts_token_if.source tx
);

    // Lexer position, one-hot
    typedef enum logic [7:0] {
        MODE_IDLE    = 8'b0000_0001,
        MODE_TEXT    = 8'b0000_0010,
        MODE_TAG     = 8'b0000_0100,
        MODE_DQ      = 8'b0000_1000,
        MODE_SQ      = 8'b0001_0000,
        MODE_ESC_DQ  = 8'b0010_0000,
        MODE_ESC_SQ  = 8'b0100_0000,
        MODE_COMMENT = 8'b1000_0000
    } mode_t;

    // Input register
    logic  in_valid_reg, in_valid_next;
    logic  in_kind_reg;
    byte_t in_byte_reg;

    // Lexer state
    mode_t      mode_reg, mode_next;
    logic [1:0] cprefix_reg, cprefix_next;   // bytes of "<!--" matched so far
    logic [1:0] cmatch_reg, cmatch_next;     // dashes seen in a comment, saturating

    // Result register
    logic   out_valid_reg, out_valid_next;
    byte_t  out_char_reg;
    logic   has_char_reg;
    tkind_t token_kind_reg;
    logic   first_reg;
    logic   last_reg;

    // Lexer step results
    logic   emit;
    byte_t  res_char;
    logic   res_has;
    tkind_t res_kind;
    logic   res_first;
    logic   res_last;
    byte_t  c;
    byte_t  want;

    logic accept;
    logic advance;
    logic load_out;

    // Move the held word into the lexer when the result slot is free, or when
    // the word produces nothing (end of input with no token open).
    assign advance  = in_valid_reg && (!out_valid_reg || tx.ready || !emit);
    assign load_out = advance && emit;
    assign rx.ready = !in_valid_reg || advance;
    assign accept   = rx.valid && rx.ready;

    assign tx.valid      = out_valid_reg;
    assign tx.out_char   = out_char_reg;
    assign tx.has_char   = has_char_reg;
    assign tx.token_kind = token_kind_reg;
    assign tx.first      = first_reg;
    assign tx.last       = last_reg;

    always_comb
    begin
        c    = hts_clean(in_byte_reg);
        want = (cprefix_reg == 2'd1) ? CH_BANG : CH_DASH;

        mode_next    = mode_reg;
        cprefix_next = cprefix_reg;
        cmatch_next  = cmatch_reg;
        emit         = 1'b1;
        res_char     = c;
        res_has      = 1'b1;
        res_kind     = KIND_TAG;
        res_first    = 1'b0;
        res_last     = 1'b0;

        if (in_kind_reg == IN_EOF)
        begin
            // Close whatever is open and go back to reset state
            emit     = (mode_reg != MODE_IDLE);
            res_char = '0;
            res_has  = 1'b0;
            res_last = 1'b1;
            if (mode_reg == MODE_TEXT)
            begin
                res_kind = KIND_TEXT;
            end
            else if (mode_reg == MODE_COMMENT)
            begin
                res_kind = KIND_COMMENT;
            end
            mode_next    = MODE_IDLE;
            cprefix_next = '0;
            cmatch_next  = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE, MODE_TEXT:
                begin
                    if (c == CH_LT)
                    begin
                        mode_next    = MODE_TAG;
                        cprefix_next = 2'd1;
                        res_first    = 1'b1;
                    end
                    else
                    begin
                        res_first = (mode_reg == MODE_IDLE);
                        res_kind  = KIND_TEXT;
                        mode_next = MODE_TEXT;
                    end
                end
                MODE_TAG:
                begin
                    if ((cprefix_reg != 2'd0) && (c == want))
                    begin
                        if (cprefix_reg == 2'd3)
                        begin
                            mode_next    = MODE_COMMENT;
                            cprefix_next = '0;
                            cmatch_next  = '0;
                            res_kind     = KIND_COMMENT;
                        end
                        else
                        begin
                            cprefix_next = cprefix_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        // Prefix broken: treat as an ordinary tag byte
                        cprefix_next = '0;
                        if (c == CH_GT)
                        begin
                            res_last  = 1'b1;
                            mode_next = MODE_IDLE;
                        end
                        else if (c == CH_DQ)
                        begin
                            mode_next = MODE_DQ;
                        end
                        else if (c == CH_SQ)
                        begin
                            mode_next = MODE_SQ;
                        end
                    end
                end
                MODE_DQ:
                begin
                    if (c == CH_DQ)
                    begin
                        mode_next = MODE_TAG;
                    end
                    else if (c == CH_BSL)
                    begin
                        mode_next = MODE_ESC_DQ;
                    end
                end
                MODE_SQ:
                begin
                    if (c == CH_SQ)
                    begin
                        mode_next = MODE_TAG;
                    end
                    else if (c == CH_BSL)
                    begin
                        mode_next = MODE_ESC_SQ;
                    end
                end
                MODE_ESC_DQ:
                begin
                    mode_next = MODE_DQ;
                end
                MODE_ESC_SQ:
                begin
                    mode_next = MODE_SQ;
                end
                MODE_COMMENT:
                begin
                    res_kind = KIND_COMMENT;
                    if (c == CH_DASH)
                    begin
                        if (cmatch_reg != 2'd2)
                        begin
                            cmatch_next = cmatch_reg + 2'd1;
                        end
                    end
                    else if ((c == CH_GT) && (cmatch_reg == 2'd2))
                    begin
                        res_last    = 1'b1;
                        mode_next   = MODE_IDLE;
                        cmatch_next = '0;
                    end
                    else
                    begin
                        cmatch_next = '0;
                    end
                end
                default:
                begin
                    mode_next    = MODE_IDLE;
                    cprefix_next = '0;
                    cmatch_next  = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            cprefix_reg   <= '0;
            cmatch_reg    <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg    <= mode_next;
                cprefix_reg <= cprefix_next;
                cmatch_reg  <= cmatch_next;
            end
        end
    end

    // Payload: hold the input word and the result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_kind_reg <= rx.kind;
            in_byte_reg <= rx.in_byte;
        end
        if (load_out)
        begin
            out_char_reg   <= res_char;
            has_char_reg   <= res_has;
            token_kind_reg <= res_kind;
            first_reg      <= res_first;
            last_reg       <= res_last;
        end
    end

    // Opening-prefix matching only happens inside a tag
    `HTS_ASSERT_NOW(a_prefix_in_tag, clk, rst_n, cprefix_reg != 2'd0, mode_reg == MODE_TAG)
    // Dash counting only happens inside a comment
    `HTS_ASSERT_NOW(a_dash_in_comment, clk, rst_n, cmatch_reg != 2'd0,
                    mode_reg == MODE_COMMENT)
    // A token start always carries a byte
    `HTS_ASSERT_NOW(a_first_has_char, clk, rst_n, out_valid_reg && first_reg, has_char_reg)
    // End of input leaves the lexer idle
    `HTS_ASSERT_NEXT(a_eof_resets, clk, rst_n, advance && (in_kind_reg == IN_EOF),
                     (mode_reg == MODE_IDLE) && (cprefix_reg == 2'd0) && (cmatch_reg == 2'd0))

endmodule
